FILE: hdl/smq_pkg.sv
// shared types, field layout and codes of the sorted multiset queue
`default_nettype none

package smq_pkg;

  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // field widths of the stream words
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POP_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 7;

  // input word: mode, value, zero pad to whole bytes
  localparam int unsigned IN_MODE_LSB  = 0;
  localparam int unsigned IN_VALUE_LSB = IN_MODE_LSB + MODE_W;
  localparam int unsigned IN_USED_W    = IN_VALUE_LSB + VALUE_W;
  localparam int unsigned IN_W         = ((IN_USED_W + 7) / 8) * 8;

  // output word: popped_value, status, removed_count, stored_count
  localparam int unsigned OUT_POP_LSB    = 0;
  localparam int unsigned OUT_STAT_LSB   = OUT_POP_LSB + POP_W;
  localparam int unsigned OUT_REM_LSB    = OUT_STAT_LSB + STAT_W;
  localparam int unsigned OUT_STORED_LSB = OUT_REM_LSB + COUNT_W;
  localparam int unsigned OUT_USED_W     = OUT_STORED_LSB + COUNT_W;
  localparam int unsigned OUT_W          = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch the accepted word
    logic step;   // delete one copy of the remove operand
    logic exec;   // finish the operation and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_remove;  // accepted word is a remove
    logic match;      // operand still present in the store
  } sts_t;

endpackage

`default_nettype wire

FILE: hdl/smq_ctrl.sv
// controller state machine of the sorted multiset queue
`default_nettype none

module smq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  output logic               s_ready_o,
  output logic               m_valid_o,
  input  wire logic          m_ready_i,
  output smq_pkg::cmd_t      cmd_o,
  input  wire smq_pkg::sts_t sts_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_q, state_d;
  logic       mvalid_q, mvalid_d;
  logic       slot_free;

  assign slot_free = !mvalid_q || m_ready_i;
  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = mvalid_q;

  always_comb begin
    state_d  = state_q;
    mvalid_d = mvalid_q;
    cmd_o    = '0;
    if (m_ready_i) begin
      mvalid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.in_remove ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        // one copy leaves per cycle until the operand is gone
        if (sts_i.match) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd_o.exec = 1'b1;
          mvalid_d   = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/smq_datapath.sv
// sorted store cells, counters and result register of the sorted multiset queue
`default_nettype none

module smq_datapath #(
  parameter int unsigned CAPACITY   = smq_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = smq_pkg::VALUE_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [smq_pkg::IN_W-1:0]  in_data_i,
  input  wire smq_pkg::cmd_t             cmd_i,
  output smq_pkg::sts_t                  sts_o,
  output logic      [smq_pkg::OUT_W-1:0] out_data_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef logic signed [VALUE_BITS-1:0] val_t;

  val_t                         store_q [CAPACITY];
  val_t                         store_d [CAPACITY];
  logic [smq_pkg::MODE_W-1:0]   op_q, op_d;
  val_t                         val_q, val_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [CNT_W-1:0]             rm_q, rm_d;
  logic [smq_pkg::OUT_W-1:0]    out_q, out_d;

  logic [CAPACITY-1:0]          live, gt, ge, eq;
  val_t                         in_val;
  logic [smq_pkg::MODE_W-1:0]   in_mode;
  logic [smq_pkg::POP_W-1:0]    res_pop;
  logic [smq_pkg::STAT_W-1:0]   res_stat;
  logic [smq_pkg::COUNT_W-1:0]  res_rem;

  assign in_mode = in_data_i[smq_pkg::IN_MODE_LSB +: smq_pkg::MODE_W];
  // sign-extend the 32-bit operand, then wrap to the stored width
  assign in_val  = val_t'(signed'(in_data_i[smq_pkg::IN_VALUE_LSB +: smq_pkg::VALUE_W]));

  // per-cell compares against the latched operand
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live[i] = CNT_W'(i) < cnt_q;
      gt[i]   = !live[i] || (store_q[i] > val_q);
      ge[i]   = live[i] && (store_q[i] >= val_q);
      eq[i]   = live[i] && (store_q[i] == val_q);
    end
  end

  assign sts_o.in_remove = (in_mode == smq_pkg::MODE_REMOVE);
  assign sts_o.match     = |eq;

  always_comb begin
    store_d  = store_q;
    op_d     = op_q;
    val_d    = val_q;
    cnt_d    = cnt_q;
    rm_d     = rm_q;
    res_pop  = '0;
    res_stat = smq_pkg::STAT_OK;
    res_rem  = '0;
    if (cmd_i.load) begin
      op_d  = in_mode;
      val_d = in_val;
      rm_d  = '0;
    end
    if (cmd_i.step) begin
      // copies are contiguous, so cells from the first copy on move down one
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (ge[i]) begin
          store_d[i] = store_q[i+1];
        end
      end
      cnt_d = cnt_q - CNT_W'(1);
      rm_d  = rm_q + CNT_W'(1);
    end
    if (cmd_i.exec) begin
      unique case (op_q)
        smq_pkg::MODE_INSERT: begin
          if (cnt_q == CNT_W'(CAPACITY)) begin
            res_stat = smq_pkg::STAT_FULL;
          end else begin
            // larger values move up one, the new value lands after equal copies
            for (int i = 0; i < CAPACITY; i++) begin
              if (gt[i]) begin
                if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                  store_d[i] = store_q[(i > 0) ? i - 1 : 0];
                end else begin
                  store_d[i] = val_q;
                end
              end
            end
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        smq_pkg::MODE_POP: begin
          if (cnt_q == '0) begin
            res_stat = smq_pkg::STAT_EMPTY;
          end else begin
            res_pop = smq_pkg::POP_W'(store_q[0]);
            for (int i = 0; i < CAPACITY - 1; i++) begin
              store_d[i] = store_q[i+1];
            end
            cnt_d   = cnt_q - CNT_W'(1);
            res_rem = smq_pkg::COUNT_W'(1);
          end
        end
        smq_pkg::MODE_REMOVE: begin
          res_rem = smq_pkg::COUNT_W'(rm_q);
          if (rm_q == '0) begin
            res_stat = smq_pkg::STAT_NOTFOUND;
          end
        end
        default: begin
        end
      endcase
    end
    out_d = out_q;
    if (cmd_i.exec) begin
      out_d = '0;
      out_d[smq_pkg::OUT_POP_LSB +: smq_pkg::POP_W]       = res_pop;
      out_d[smq_pkg::OUT_STAT_LSB +: smq_pkg::STAT_W]     = res_stat;
      out_d[smq_pkg::OUT_REM_LSB +: smq_pkg::COUNT_W]     = res_rem;
      out_d[smq_pkg::OUT_STORED_LSB +: smq_pkg::COUNT_W]  = smq_pkg::COUNT_W'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
    op_q    <= op_d;
    val_q   <= val_d;
    rm_q    <= rm_d;
    out_q   <= out_d;
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

FILE: hdl/sorted_multiset_queue.sv
// sorted multiset queue: ascending store of signed values with insert, pop and remove
//
// input stream (s_axis): one word per operation, mode and value in tdata
//   insert places value after equal copies, refused with status full when the store holds CAPACITY
//   pop returns the smallest value, status empty when nothing is held
//   remove deletes every copy of value and reports how many went, status not found if none
// output stream (m_axis): exactly one word per operation, in order
// steps: insert, pop and the unused mode go through accept, then the shifting cell update;
//   remove goes through accept, one shift down per copy deleted, a scan step that finds no
//   copy left, then the finish step
// only one operation is in flight; the next word is accepted as soon as the result sits in the
//   output register, and the finish step waits while that register is still full
// a stalled receiver holds the result word stable and eventually blocks the input side
// reset clears the held count and the output valid; the store cells are not cleared and
//   need no clearing pass
`default_nettype none

module sorted_multiset_queue #(
  parameter int unsigned CAPACITY   = smq_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = smq_pkg::VALUE_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // mode [1:0], value [33:2], zero [39:34]
  input  wire logic [smq_pkg::IN_W-1:0]  s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  // popped_value [31:0], status [33:32], removed_count [40:34], stored_count [47:41]
  output logic      [smq_pkg::OUT_W-1:0] m_axis_tdata_o
);

  smq_pkg::cmd_t cmd;
  smq_pkg::sts_t sts;

  smq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  smq_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

FILE: hdl/smq_checker.sv
// port-level checker of the sorted multiset queue and its bind
`default_nettype none

module smq_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     s_axis_tvalid_i,
  input wire logic                     s_axis_tready_o,
  input wire logic [smq_pkg::IN_W-1:0] s_axis_tdata_i,
  input wire logic                     m_axis_tvalid_o,
  input wire logic                     m_axis_tready_i,
  input wire logic [smq_pkg::OUT_W-1:0] m_axis_tdata_o
);

  logic [smq_pkg::STAT_W-1:0]  stat;
  logic [smq_pkg::POP_W-1:0]   popped;
  logic [smq_pkg::COUNT_W-1:0] removed, stored;

  assign stat    = m_axis_tdata_o[smq_pkg::OUT_STAT_LSB +: smq_pkg::STAT_W];
  assign popped  = m_axis_tdata_o[smq_pkg::OUT_POP_LSB +: smq_pkg::POP_W];
  assign removed = m_axis_tdata_o[smq_pkg::OUT_REM_LSB +: smq_pkg::COUNT_W];
  assign stored  = m_axis_tdata_o[smq_pkg::OUT_STORED_LSB +: smq_pkg::COUNT_W];

  // once reset has been seen, no result word is offered on the next edge
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result word offered during reset");

  // a new word is never taken in the cycle after one was accepted
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second word accepted while an operation is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result word changed");

  // a pop on an empty store leaves it empty and returns nothing
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && stat == smq_pkg::STAT_EMPTY) |->
      (popped == '0 && removed == '0 && stored == '0))
    else $error("empty pop reports data or a count");

  // a failed remove deletes nothing
  a_notfound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && stat == smq_pkg::STAT_NOTFOUND) |-> (removed == '0 && popped == '0))
    else $error("remove not found reports deleted copies");

endmodule

bind sorted_multiset_queue smq_checker u_smq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
